// File: hw/rtl/iatan_pkg.sv
// Package for the integer atan2 binary angle unit.
// Holds index width constants and the arctangent table; no dependencies.
package iatan_pkg;

    localparam int INDEX_FRACTION_BITS_DEF = 8;
    localparam int COORD_W = 32;
    localparam int ANGLE_W = 11;

    // Binary angle units per radian, 512/pi
    localparam real BAM_PER_RADIAN = 512.0 / 3.14159265358979323846;

    // Arctangent in binary units for an index of f fraction bits; elaboration only.
    function automatic logic [7:0] atan_lookup(input int idx, input int f);
        real a;
        real v;
        a = $atan(real'(idx) * (2.0 ** (-f)));
        v = a * BAM_PER_RADIAN + 0.5;
        if (v > 255.0) begin
            v = 255.0;
        end
        atan_lookup = 8'($rtoi(v));
    endfunction

endpackage

// File: hw/rtl/iatan_div_stage.sv
// One restoring division step: one quotient bit per stage, registered.
// Depends on nothing but its parameters.
module iatan_div_stage #(
    parameter int NW = 32,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW:0]   i_rem,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_num,
    output logic [DW:0]   o_rem
);
    logic [DW+1:0] sh;
    logic [DW+1:0] df;
    always_comb begin
        sh = {i_rem, i_num[NW-1]};
        df = sh - {2'b0, i_den};
    end
    // Shift numerator, keep quotient bit in its low end
    always_ff @(posedge i_clk) begin
        if (!df[DW+1]) begin
            o_rem <= df[DW:0];
        end else begin
            o_rem <= sh[DW:0];
        end
        o_num <= {i_num[NW-2:0], ~df[DW+1]};
    end
endmodule

// File: hw/rtl/integer_atan2_binary_angle_unit.sv
// Top level of the integer atan2 binary angle unit.
// Uses iatan_pkg and iatan_div_stage.
//
// Usage: drive i_y_coord and i_x_coord with i_start high. busy is always low,
// so one item is taken every cycle. Each item runs through a fixed pipeline:
// one fold stage, 32 restoring divider stages (one quotient bit each, for
// the 32-bit quotient of smaller*2^32/larger), one rounding stage, one table
// stage and one output stage. The fold stage loads at the accepting edge, and
// o_valid goes high in the same cycle that the output stage holds the result.
// The sustained rate is one item per cycle, since every stage takes a new item
// each cycle.
// The result is shown on o_angle for one cycle with o_valid high; the
// receiver cannot stall, so nothing is held. Reset clears all valid bits;
// items in flight are dropped. The table is constant logic, no fill.
// The short-ratio rounding (s*2^F + l/2)/l is derived from the same
// quotient: with q = floor(s*2^32/l), that index equals the rounded
// value of q at bit 31-F, the same as the long case.
module integer_atan2_binary_angle_unit #(
    parameter int INDEX_FRACTION_BITS = iatan_pkg::INDEX_FRACTION_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [iatan_pkg::COORD_W-1:0] i_y_coord,
    input  logic signed [iatan_pkg::COORD_W-1:0] i_x_coord,
    output logic                                 o_busy,
    output logic                                 o_valid,
    output logic signed [iatan_pkg::ANGLE_W-1:0] o_angle
);
    import iatan_pkg::*;

    localparam int F = INDEX_FRACTION_BITS;
    localparam int DEPTH = (1 << F) + 1;
    localparam int IW = F + 1;
    localparam int NS = 32;
    localparam int LAT = NS + 4;

    typedef struct packed {
        logic                      eq;
        logic                      sub;
        logic signed [ANGLE_W-1:0] base;
    } t_side;

    assign o_busy = 1'b0;

    // Stage 0: fold into first octant
    logic [31:0] ymag, xmag;
    t_side n_side;
    logic [31:0] n_small, n_large;
    always_comb begin
        ymag = i_y_coord[31] ? 32'(-i_y_coord) : i_y_coord;
        xmag = i_x_coord[31] ? 32'(-i_x_coord) : i_x_coord;
        n_side.sub = i_x_coord[31];
        n_side.base = i_x_coord[31] ? 11'sd512 : 11'sd0;
        if (i_y_coord[31]) begin
            n_side.sub = ~n_side.sub;
            n_side.base = -n_side.base;
        end
        if (xmag < ymag) begin
            n_small = xmag;
            n_large = ymag;
            n_side.base = n_side.sub ? n_side.base - 11'sd256 : n_side.base + 11'sd256;
            n_side.sub = ~n_side.sub;
        end else begin
            n_small = ymag;
            n_large = xmag;
        end
        n_side.eq = (n_small == n_large);
    end

    logic [31:0] r_num [NS+1];
    logic [32:0] r_rem [NS+1];
    logic [31:0] r_den [NS+1];
    t_side       r_side [LAT];
    logic [LAT-1:0] r_vld;

    // Smaller starts as the remainder; while it is below larger,
    // 32 steps over zero bits give floor(smaller*2^32/larger)
    always_ff @(posedge i_clk) begin
        r_num[0] <= '0;
        r_rem[0] <= {1'b0, n_small};
        r_den[0] <= n_large;
        r_side[0] <= n_side;
    end

    // Divider chain; divisor and side info ride along
    for (genvar g = 0; g < NS; g++) begin : g_div
        iatan_div_stage #(.NW(32), .DW(32)) u_stage (
            .i_clk(i_clk), .i_num(r_num[g]), .i_rem(r_rem[g]), .i_den(r_den[g]),
            .o_num(r_num[g+1]), .o_rem(r_rem[g+1])
        );
        always_ff @(posedge i_clk) begin
            r_den[g+1] <= r_den[g];
            r_side[g+1] <= r_side[g];
        end
    end

    // Rounding stage: quotient fills the numerator register
    logic [31:0] q;
    logic [32:0] n_idx;
    logic [IW-1:0] r_idx;
    always_comb begin
        q = r_num[NS];
        n_idx = 33'(q >> (32 - F)) + 33'(q[31-F]);
    end
    always_ff @(posedge i_clk) begin
        r_idx <= (n_idx >= 33'(DEPTH)) ? IW'(DEPTH - 1) : n_idx[IW-1:0];
        r_side[NS+1] <= r_side[NS];
    end

    // Arctangent table, one constant entry per index
    logic [7:0] rom_table [DEPTH];
    for (genvar t = 0; t < DEPTH; t++) begin : g_rom
        localparam logic [7:0] ENTRY = atan_lookup(t, F);
        assign rom_table[t] = ENTRY;
    end

    // Table stage
    logic [7:0] r_atv;
    always_ff @(posedge i_clk) begin
        r_atv <= r_side[NS+1].eq ? 8'h80 : rom_table[r_idx];
        r_side[NS+2] <= r_side[NS+1];
    end

    // Combine stage
    logic signed [ANGLE_W-1:0] r_angle;
    always_ff @(posedge i_clk) begin
        r_angle <= r_side[NS+2].sub ? r_side[NS+2].base - $signed({3'b0, r_atv})
                                    : r_side[NS+2].base + $signed({3'b0, r_atv});
        r_side[NS+3] <= r_side[NS+2];
    end

    // Valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_start};
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_angle = r_angle;

    // Equal magnitudes always land on a diagonal multiple of 128
    a_eq_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_side[NS+3].eq |-> r_angle[6:0] == 7'd0)
        else $error("diagonal angle not multiple of 128");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##(LAT) o_valid)
        else $error("result missing after pipeline latency");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_angle <= 11'sd512) && (o_angle >= -11'sd512))
        else $error("angle out of range");
endmodule
